// File: src/iacl_pkg.sv
package iacl_pkg;

    // Field widths of the stream payloads
    localparam int SLOT_W      = 4;
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ACL_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 1'b1;

    // Request kinds carried in s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // Prefix length at which a rule covers a single address
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } ctrl_state_t;

    // One stored rule: inclusive address range and its verdict
    typedef struct packed {
        logic [ADDR_W-1:0] range_lo;
        logic [ADDR_W-1:0] range_hi;
        logic              deny;
    } rule_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the input beat, write a rule if it is one
        logic scan;      // issue the next rule read
        logic finish;    // latch the verdict of the compare stage
        logic load_out;  // move the verdict into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_check;  // input beat is a check with the filter enabled
        logic cmp_done;  // compare stage has decided the verdict
        logic out_free;  // output register can take a beat this cycle
    } dp_sts_t;

endpackage

// File: src/iacl_ctrl.sv
module iacl_ctrl
    import iacl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_sts_t    sts,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.is_check ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (sts.cmp_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A decided scan always hands over to the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sts.cmp_done) |=> (state_reg == ST_RESULT))
        else $error("scan did not hand over to result");

    // A beat accepted in idle leaves idle on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

endmodule

// File: src/iacl_dp.sv
module iacl_dp
    import iacl_pkg::*;
#(
    parameter int NUM_RULES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  ctrl_cmd_t              cmd,
    output dp_sts_t                sts
);

    localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    // Unpacked input fields
    logic [SLOT_W-1:0] in_slot;
    logic [ADDR_W-1:0] in_addr;
    logic [PLEN_W-1:0] in_plen;
    logic              in_deny;

    assign in_slot = s_tdata[3:0];
    assign in_addr = s_tdata[35:4];
    assign in_plen = s_tdata[41:36];
    assign in_deny = s_tdata[42];

    // Configuration registers
    logic                  acl_enable_reg;
    logic [CFG_DATA_W-1:0] rule_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acl_enable_reg <= 1'b0;
            rule_count_reg <= CFG_DATA_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ACL_ENABLE: acl_enable_reg <= cfg_wr_data[0];
                CFG_RULE_COUNT: rule_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Rule construction from base address and prefix length
    logic [PLEN_W-1:0]       plen_sat;
    logic [ADDR_W-1:0]       net_mask;
    rule_t                   wr_rule;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_en;

    always_comb begin
        plen_sat         = (in_plen > PLEN_MAX) ? PLEN_MAX : in_plen;
        net_mask         = ~({ADDR_W{1'b1}} >> plen_sat);
        wr_rule.range_lo = in_addr & net_mask;
        wr_rule.range_hi = in_addr | ~net_mask;
        wr_rule.deny     = in_deny;
        slot_ext         = (IDX_W+SLOT_W)'(in_slot);
        wr_addr          = slot_ext[IDX_W-1:0];
        wr_en            = cmd.capture && (s_tuser == REQ_WRITE)
                           && (32'(in_slot) < 32'(NUM_RULES));
    end

    // Index of the last rule in use, with the count clamped to the table
    logic [31:0]      count_clamped;
    logic [IDX_W-1:0] last_next;

    always_comb begin
        if (rule_count_reg == '0) begin
            count_clamped = 32'd1;
        end else if (32'(rule_count_reg) > 32'(NUM_RULES)) begin
            count_clamped = 32'(NUM_RULES);
        end else begin
            count_clamped = 32'(rule_count_reg);
        end
        last_next = IDX_W'(count_clamped - 32'd1);
    end

    // Captured check address and scan bound
    logic [ADDR_W-1:0] addr_reg;
    logic [IDX_W-1:0]  last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= in_addr;
            last_reg <= last_next;
        end
    end

    // Scan counter: one rule read issued per cycle up to the last rule
    logic [IDX_W:0]   idx_reg;
    logic             rd_issue;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    rule_t            rd_rule_reg;

    assign rd_issue = cmd.scan && ({1'b0, last_reg} >= idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_issue;
            if (cmd.capture) begin
                idx_reg <= '0;
            end else if (rd_issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        end
    end

    // Rule memory: one write port, one registered read port
    rule_t rule_mem [NUM_RULES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_addr] <= wr_rule;
        end
        if (rd_issue) begin
            rd_rule_reg <= rule_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Compare stage
    logic                    cmp_hit;
    logic                    cmp_last;
    logic [IDX_W+SLOT_W-1:0] rd_idx_ext;

    always_comb begin
        cmp_hit    = (addr_reg >= rd_rule_reg.range_lo)
                     && (addr_reg <= rd_rule_reg.range_hi);
        cmp_last   = (rd_idx_reg == last_reg);
        rd_idx_ext = (IDX_W+SLOT_W)'(rd_idx_reg);
    end

    // Pending verdict: zeros for writes and disabled checks
    logic              res_denied_reg;
    logic              res_hit_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_denied_reg <= 1'b0;
            res_hit_reg    <= 1'b0;
            res_slot_reg   <= '0;
        end else if (cmd.finish) begin
            if (cmp_hit) begin
                res_denied_reg <= rd_rule_reg.deny;
                res_hit_reg    <= 1'b1;
                res_slot_reg   <= rd_idx_ext[SLOT_W-1:0];
            end else begin
                res_denied_reg <= ~rd_rule_reg.deny;
                res_hit_reg    <= 1'b0;
                res_slot_reg   <= '0;
            end
        end
    end

    // Output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, res_slot_reg, res_hit_reg, res_denied_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status back to the controller
    assign sts.is_check = (s_tuser == REQ_CHECK) && acl_enable_reg;
    assign sts.cmp_done = rd_valid_reg && (cmp_hit || cmp_last);
    assign sts.out_free = !out_valid_reg || m_tready;

    // A verdict never overwrites a beat that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output beat overwritten");

    // Rule writes happen only when a write beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (cmd.capture && !cmd.scan))
        else $error("rule write outside capture");

    // The compare stage never looks past the last rule in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (rd_idx_reg <= last_reg))
        else $error("scan went past last rule");

endmodule

// File: src/ipv4_acl_first_match.sv
// A rule write or a check with the filter disabled goes from idle to the result state. An
// enabled check reads one rule per cycle through the table's read port, lowest index first,
// until the compare stage hits or reaches the last rule in use, and latches the verdict.
// The verdict moves into the output register once it is free; only then is the next input
// beat taken, so one item is handled at a time.
// Reset clears control and configuration (filter off, one rule); the table is not cleared.
module ipv4_acl_first_match
    import iacl_pkg::*;
#(
    parameter int NUM_RULES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] rule_slot, [35:4] ip_address, [41:36] prefix_len, [42] deny_flag
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] denied, [1] rule_hit, [5:2] hit_slot
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    iacl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iacl_dp #(
        .NUM_RULES (NUM_RULES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
